// File: rtl/lbct_pkg.sv
// ----------------------------------------------------------------------------
// lbct_pkg
// Types and constants shared by the LED blink-code timer modules.
// ----------------------------------------------------------------------------
package lbct_pkg;

    localparam int MODE_W       = 2;
    localparam int LOAD_W       = 8;
    localparam int CFG_TIME_W   = 16;
    localparam int CFG_INDEX_W  = 8;
    localparam int PRESCALE_W   = 5;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_TX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLAG    = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIME   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TIME = 8'd1;

    localparam logic [CFG_TIME_W-1:0] GAP_TIME_RESET   = 16'd500;
    localparam logic [CFG_TIME_W-1:0] PULSE_TIME_RESET = 16'd100;

    localparam logic [PRESCALE_W-1:0] STATUS_ON_PRESCALE  = 5'd30;
    localparam logic [PRESCALE_W-1:0] STATUS_OFF_PRESCALE = 5'd10;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LOAD_W-1:0] load_value;
    } in_t;

    typedef struct packed {
        logic rx_led;
        logic tx_led;
        logic status_led;
    } out_t;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] gap_time;
        logic [CFG_TIME_W-1:0] pulse_time;
    } timing_t;

    typedef struct packed {
        logic tick;
        logic load;
    } chan_ctl_t;

endpackage

// File: rtl/led_blink_code_timer_unit.sv
// ----------------------------------------------------------------------------
// led_blink_code_timer_unit
// Tick-driven LED blink-code timer: two pulse-count channels and a slow
// status blink, one LED level result per input beat.
//
//   channel | ports                               | beat
//   --------+-------------------------------------+-----------------------
//   input   | s_valid s_ready s_data              | mode, load_value
//   result  | m_valid m_ready m_data              | rx/tx/status LED levels
//   config  | cfg_valid cfg_ready cfg_index/data  | register write
//
// One beat per cycle unless stalled: all channel updates happen in the
// accepting cycle and the levels land in the result register, visible the
// next cycle. The result register is the only stage; s_ready drops only
// while it holds a beat that m_ready refuses. Config writes are always taken.
// Synchronous active-low reset clears all timers, counts and channel LEDs.
// ----------------------------------------------------------------------------
module led_blink_code_timer_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lbct_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lbct_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lbct_pkg::CFG_TIME_W-1:0]     cfg_data
);

    lbct_pkg::timing_t timing_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;

    logic accept;
    logic tick;
    lbct_pkg::chan_ctl_t rx_ctl, tx_ctl;
    logic rx_led_next, tx_led_next;

    logic                              m_valid_reg;
    lbct_pkg::out_t                    m_data_reg;

    // status channel
    logic [TIME_BITS-1:0]               st_ref_reg, st_ref_next;
    logic                               st_phase_reg, st_phase_next;
    logic                               st_flag_reg, st_flag_next;
    logic [lbct_pkg::PRESCALE_W-1:0]    st_pre_reg, st_pre_next;
    logic                               st_led_reg, st_led_next;
    logic [TIME_BITS-1:0]               st_elapsed;
    logic [TIME_BITS-1:0]               gap_ext, pulse_ext;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign accept = s_valid && s_ready;
    assign tick   = accept && (s_data.mode == lbct_pkg::MODE_TICK);
    assign rx_ctl = '{tick: tick, load: accept && (s_data.mode == lbct_pkg::MODE_LOAD_RX)};
    assign tx_ctl = '{tick: tick, load: accept && (s_data.mode == lbct_pkg::MODE_LOAD_TX)};

    assign now_next = now_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.gap_time   <= lbct_pkg::GAP_TIME_RESET;
            timing_reg.pulse_time <= lbct_pkg::PULSE_TIME_RESET;
        end else if (cfg_valid && (cfg_data != '0)) begin
            if (cfg_index == lbct_pkg::REG_GAP_TIME) begin
                timing_reg.gap_time <= cfg_data;
            end else if (cfg_index == lbct_pkg::REG_PULSE_TIME) begin
                timing_reg.pulse_time <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg <= '0;
        end else if (tick) begin
            now_reg <= now_next;
        end
    end

    lbct_pulse_ch #(.TIME_BITS(TIME_BITS)) u_rx_ch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (rx_ctl),
        .load_value (s_data.load_value),
        .now_cur    (now_reg),
        .now_tick   (now_next),
        .timing     (timing_reg),
        .led_next   (rx_led_next)
    );

    lbct_pulse_ch #(.TIME_BITS(TIME_BITS)) u_tx_ch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (tx_ctl),
        .load_value (s_data.load_value),
        .now_cur    (now_reg),
        .now_tick   (now_next),
        .timing     (timing_reg),
        .led_next   (tx_led_next)
    );

    assign gap_ext    = TIME_BITS'(timing_reg.gap_time);
    assign pulse_ext  = TIME_BITS'(timing_reg.pulse_time);
    assign st_elapsed = now_next - st_ref_reg;

    always_comb begin
        st_ref_next   = st_ref_reg;
        st_phase_next = st_phase_reg;
        st_flag_next  = st_flag_reg;
        st_pre_next   = st_pre_reg;
        st_led_next   = st_led_reg;
        if (accept && (s_data.mode == lbct_pkg::MODE_FLAG)) begin
            st_flag_next = s_data.load_value[0];
        end else if (tick) begin
            if (!st_phase_reg) begin
                if (st_elapsed > pulse_ext) begin
                    st_ref_next = st_ref_reg + pulse_ext;
                    if (st_pre_reg == '0) begin
                        st_pre_next   = lbct_pkg::STATUS_ON_PRESCALE;
                        st_led_next   = st_flag_reg;
                        st_phase_next = 1'b1;
                    end else begin
                        st_pre_next = st_pre_reg - 1'b1;
                    end
                end
            end else if (st_elapsed > gap_ext) begin
                if (st_pre_reg == '0) begin
                    st_pre_next   = lbct_pkg::STATUS_OFF_PRESCALE;
                    st_ref_next   = st_ref_reg + gap_ext;
                    st_led_next   = !st_flag_reg;
                    st_phase_next = 1'b0;
                end else begin
                    // countdown steps by pulse_time here, not gap_time
                    st_pre_next = st_pre_reg - 1'b1;
                    st_ref_next = st_ref_reg + pulse_ext;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_ref_reg   <= '0;
            st_phase_reg <= 1'b0;
            st_flag_reg  <= 1'b0;
            st_pre_reg   <= '0;
            st_led_reg   <= 1'b0;
        end else begin
            st_ref_reg   <= st_ref_next;
            st_phase_reg <= st_phase_next;
            st_flag_reg  <= st_flag_next;
            st_pre_reg   <= st_pre_next;
            st_led_reg   <= st_led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.rx_led     <= rx_led_next;
            m_data_reg.tx_led     <= tx_led_next;
            m_data_reg.status_led <= st_led_next;
        end
    end

endmodule

// File: rtl/lbct_pulse_ch.sv
// ----------------------------------------------------------------------------
// lbct_pulse_ch
// One pulse-count channel: blinks a loaded number of pulses.
// ----------------------------------------------------------------------------
module lbct_pulse_ch #(
    parameter int TIME_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lbct_pkg::chan_ctl_t            ctl,
    input  logic [lbct_pkg::LOAD_W-1:0]    load_value,
    input  logic [TIME_BITS-1:0]           now_cur,
    input  logic [TIME_BITS-1:0]           now_tick,
    input  lbct_pkg::timing_t              timing,
    output logic                           led_next
);

    logic [TIME_BITS-1:0]        ref_reg, ref_next;
    logic                        phase_reg, phase_next;
    logic [lbct_pkg::LOAD_W-1:0] pending_reg, pending_next;
    logic                        led_reg;

    logic [TIME_BITS-1:0] gap_ext;
    logic [TIME_BITS-1:0] pulse_ext;
    logic [TIME_BITS-1:0] elapsed;

    assign gap_ext   = TIME_BITS'(timing.gap_time);
    assign pulse_ext = TIME_BITS'(timing.pulse_time);
    assign elapsed   = now_tick - ref_reg;

    always_comb begin
        ref_next     = ref_reg;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        led_next     = led_reg;
        if (ctl.load) begin
            ref_next     = now_cur - gap_ext;
            pending_next = load_value;
        end else if (ctl.tick) begin
            if (!phase_reg) begin
                if (elapsed > pulse_ext) begin
                    ref_next   = ref_reg + pulse_ext;
                    led_next   = 1'b0;
                    phase_next = 1'b1;
                end
            end else if ((pending_reg != '0) && (elapsed > gap_ext)) begin
                ref_next     = ref_reg + gap_ext;
                led_next     = 1'b1;
                pending_next = pending_reg - 1'b1;
                phase_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg     <= '0;
            phase_reg   <= 1'b0;
            pending_reg <= '0;
            led_reg     <= 1'b0;
        end else begin
            ref_reg     <= ref_next;
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            led_reg     <= led_next;
        end
    end

endmodule
